// ===== rtl/core/dbdl_pkg.sv =====
// Shared widths, register codes, sideband types and the divider step for the detail level block.
package dbdl_pkg;

  localparam int unsigned DIST_W         = 32;
  localparam int unsigned FRAC_W         = 16;
  localparam int unsigned LVL_W          = 2;
  localparam int unsigned CNT_W          = 2;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned MAX_LEVELS_DEF = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD_A     = 3'd0,
    REG_THRESHOLD_B     = 3'd1,
    REG_THRESHOLD_C     = 3'd2,
    REG_BLEND_END_A     = 3'd3,
    REG_BLEND_END_B     = 3'd4,
    REG_BLEND_END_C     = 3'd5,
    REG_THRESHOLD_COUNT = 3'd6,
    REG_BLEND_COUNT     = 3'd7
  } cfg_reg_e;

  // result sideband carried alongside the divider
  typedef struct packed {
    logic [LVL_W-1:0] level_whole;
    logic             is_blending;
  } tag_t;

  typedef struct packed {
    logic [DIST_W-1:0] rem;
    logic              qbit;
  } div_step_t;

  // one restoring division step; rem is below den on entry and on exit
  function automatic div_step_t div_step(logic [DIST_W-1:0] rem, logic [DIST_W-1:0] den);
    logic [DIST_W:0] shl;
    div_step_t       res;
    shl = {rem, 1'b0};
    if (shl >= {1'b0, den}) begin
      res.rem  = DIST_W'(shl - {1'b0, den});
      res.qbit = 1'b1;
    end else begin
      res.rem  = shl[DIST_W-1:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/distance_to_blended_detail_level_core.sv =====
// Top level: distance to blended detail level, with config registers and result pipeline.
//
// Usage
//   s_axis carries one view distance per item (Q16.16 in tdata[31:0]).
//   m_axis returns one result per item: tdata[1:0] level_whole,
//   tdata[17:2] level_fraction (Q0.16), tuser is_blending.
//   cfg: index/data write port, always ready; write only while idle.
// Timing
//   From input accept to output valid an item passes through two stages of
//   compare/select and subtract, then sixteen divider stages, one quotient
//   bit each, the last of which is the output register.
//   Throughput one item per cycle while m_axis_tready is high; the divider chain sets the depth.
// Stalls
//   Each stage holds its item while the next is full and stalled; bubbles
//   are squeezed out, so s_axis_tready only drops when every stage holds
//   an item and m_axis_tready is low. Nothing is lost or repeated.
// Reset
//   rst_ni clears all valid bits and all config registers to zero
//   (no thresholds in use: every distance maps to level 0).
module distance_to_blended_detail_level_core #(
  parameter int unsigned MAX_LEVELS = dbdl_pkg::MAX_LEVELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // view_distance[31:0]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,
  // level_whole[1:0], level_fraction[17:2], zero[23:18]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,
  // is_blending[0]
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dbdl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);

  localparam int unsigned DW = dbdl_pkg::DIST_W;
  localparam int unsigned LW = dbdl_pkg::LVL_W;
  localparam int unsigned IW = dbdl_pkg::CFG_IDX_W;
  localparam logic [LW-1:0] MAX_CNT = LW'(MAX_LEVELS);

  // ---------------- configuration registers ----------------
  logic [DW-1:0]                thr_q  [MAX_LEVELS];
  logic [DW-1:0]                bend_q [MAX_LEVELS];
  logic [dbdl_pkg::CNT_W-1:0]   thr_cnt_q, blend_cnt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_LEVELS; k++) begin
        thr_q[k]  <= '0;
        bend_q[k] <= '0;
      end
      thr_cnt_q   <= '0;
      blend_cnt_q <= '0;
    end else if (cfg_valid_i) begin
      // thresholds beyond MAX_LEVELS are never in use, so they are not stored
      for (int k = 0; k < MAX_LEVELS; k++) begin
        if (cfg_index_i == IW'(dbdl_pkg::REG_THRESHOLD_A) + IW'(k)) thr_q[k]  <= cfg_data_i;
        if (cfg_index_i == IW'(dbdl_pkg::REG_BLEND_END_A) + IW'(k)) bend_q[k] <= cfg_data_i;
      end
      if (cfg_index_i == dbdl_pkg::REG_THRESHOLD_COUNT) thr_cnt_q   <= cfg_data_i[1:0];
      if (cfg_index_i == dbdl_pkg::REG_BLEND_COUNT)     blend_cnt_q <= cfg_data_i[1:0];
    end
  end

  // counts in use, limited to MAX_LEVELS
  logic [LW-1:0] nt, nb;
  assign nt = (thr_cnt_q   > MAX_CNT) ? MAX_CNT : thr_cnt_q;
  assign nb = (blend_cnt_q > MAX_CNT) ? MAX_CNT : blend_cnt_q;

  // ---------------- handshake chain ----------------
  logic va_q, vb_q;
  logic rdy_a, rdy_b, div_rdy;

  assign rdy_b         = !vb_q || div_rdy;
  assign rdy_a         = !va_q || rdy_b;
  assign s_axis_tready = rdy_a;

  // ---------------- stage A: level, blend index, band bounds ----------------
  logic [DW-1:0] d_in;
  logic [LW-1:0] lvl_c, bi_c;
  logic [DW-1:0] lo_c, hi_c;
  logic          cand_c;

  assign d_in = s_axis_tdata[DW-1:0];

  always_comb begin
    logic [LW-1:0] bi_raw;
    lvl_c  = nt;
    bi_raw = nb;
    // first threshold in use above the distance; scan from the top so the
    // lowest match wins
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (LW'(i) < nt && thr_q[i]  > d_in) lvl_c  = LW'(i);
      if (LW'(i) < nb && bend_q[i] > d_in) bi_raw = LW'(i);
    end
    // clamp blend index to [lvl-1, lvl]
    bi_c = bi_raw;
    if (bi_c > lvl_c) bi_c = lvl_c;
    if (lvl_c != '0 && bi_c < lvl_c - LW'(1)) bi_c = lvl_c - LW'(1);
    cand_c = (nb != '0) && (lvl_c != '0) && (bi_c != lvl_c) && (bi_c < nb);
    lo_c = '0;
    hi_c = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (LW'(i) == bi_c) begin
        lo_c = thr_q[i];
        hi_c = bend_q[i];
      end
    end
    // band end capped by the next threshold in use
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (LW'(i) == lvl_c && lvl_c < nt && thr_q[i] < hi_c) hi_c = thr_q[i];
    end
  end

  logic [DW-1:0] a_d_q, a_lo_q, a_hi_q;
  logic [LW-1:0] a_lvl_q, a_bi_q;
  logic          a_cand_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      a_d_q    <= d_in;
      a_lo_q   <= lo_c;
      a_hi_q   <= hi_c;
      a_lvl_q  <= lvl_c;
      a_bi_q   <= bi_c;
      a_cand_q <= cand_c;
    end
  end

  // ---------------- stage B: band test and divider operands ----------------
  logic          inband_c;
  assign inband_c = a_cand_q && (a_lo_q <= a_d_q) && (a_d_q < a_hi_q);

  logic [DW-1:0]  b_num_q, b_den_q;
  dbdl_pkg::tag_t b_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (rdy_b) begin
      vb_q <= va_q;
    end
  end

  // outside the band the divider sees 0/1, giving a zero fraction
  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      b_num_q             <= inband_c ? (a_d_q - a_lo_q) : '0;
      b_den_q             <= inband_c ? (a_hi_q - a_lo_q) : DW'(1);
      b_tag_q.level_whole <= inband_c ? a_bi_q : a_lvl_q;
      b_tag_q.is_blending <= inband_c;
    end
  end

  // ---------------- divider: (d - a) * 2^16 / (b - a) ----------------
  logic [dbdl_pkg::FRAC_W-1:0] frac;
  dbdl_pkg::tag_t              out_tag;

  dbdl_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vb_q),
    .in_ready_o  (div_rdy),
    .num_i       (b_num_q),
    .den_i       (b_den_q),
    .tag_i       (b_tag_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .quot_o      (frac),
    .tag_o       (out_tag)
  );

  assign m_axis_tdata = {6'b0, frac, out_tag.level_whole};
  assign m_axis_tuser = out_tag.is_blending;

endmodule

// ===== rtl/core/dbdl_div.sv =====
// Pipelined fraction divider: one quotient bit per stage, stall-safe handshake per stage.
module dbdl_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dbdl_pkg::DIST_W-1:0]  num_i,
  input  logic [dbdl_pkg::DIST_W-1:0]  den_i,
  input  dbdl_pkg::tag_t               tag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dbdl_pkg::FRAC_W-1:0]  quot_o,
  output dbdl_pkg::tag_t               tag_o
);

  localparam int unsigned STEPS = dbdl_pkg::FRAC_W;

  logic [STEPS-1:0]                 v_q;
  logic [STEPS:0]                   rdy;
  logic [dbdl_pkg::DIST_W-1:0]      rem_q [STEPS];
  logic [dbdl_pkg::DIST_W-1:0]      den_q [STEPS];
  logic [dbdl_pkg::FRAC_W-1:0]      quo_q [STEPS];
  dbdl_pkg::tag_t                   tag_q [STEPS];

  // a stage may load when empty or when its successor moves on
  always_comb begin
    rdy[STEPS] = out_ready_i;
    for (int k = STEPS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < STEPS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dbdl_pkg::div_step_t st;
    if (rdy[0]) begin
      st       = dbdl_pkg::div_step(num_i, den_i);
      rem_q[0] <= st.rem;
      den_q[0] <= den_i;
      quo_q[0] <= {{(dbdl_pkg::FRAC_W-1){1'b0}}, st.qbit};
      tag_q[0] <= tag_i;
    end
    for (int k = 1; k < STEPS; k++) begin
      if (rdy[k]) begin
        st       = dbdl_pkg::div_step(rem_q[k-1], den_q[k-1]);
        rem_q[k] <= st.rem;
        den_q[k] <= den_q[k-1];
        quo_q[k] <= {quo_q[k-1][dbdl_pkg::FRAC_W-2:0], st.qbit};
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  assign out_valid_o = v_q[STEPS-1];
  assign quot_o      = quo_q[STEPS-1];
  assign tag_o       = tag_q[STEPS-1];

endmodule

// ===== rtl/core/dbdl_checker.sv =====
// Port-level checks for the detail level block, bound to the top level.
module dbdl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // no blend band: fraction must be zero
  a_frac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[17:2] == 16'd0))
    else $error("fraction nonzero outside blend band");

  // blending reports one below a level index, so never the top level
  a_blend_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("blend level out of range");

  // an empty output register means the whole pipeline can take an item
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output item dropped under stall");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output item changed under stall");

endmodule

bind distance_to_blended_detail_level_core dbdl_checker u_dbdl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/distance_to_blended_detail_level_core_tb.sv =====
// Self-checking testbench for the distance to blended detail level core.
module distance_to_blended_detail_level_core_tb;

  localparam int unsigned DIST_W         = dbdl_pkg::DIST_W;
  localparam int unsigned FRAC_W         = dbdl_pkg::FRAC_W;
  localparam int unsigned LVL_W          = dbdl_pkg::LVL_W;
  localparam int unsigned CNT_W          = dbdl_pkg::CNT_W;
  localparam int unsigned CFG_IDX_W      = dbdl_pkg::CFG_IDX_W;
  localparam int unsigned MAX_LEVELS     = dbdl_pkg::MAX_LEVELS_DEF;
  localparam int unsigned PIPE_LATENCY   = 18;
  localparam int unsigned DRAIN_CYCLES   = PIPE_LATENCY + 4;
  localparam int unsigned HOLD_CYCLES    = 120;   // long output back-pressure
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 110;
  localparam int unsigned PLAN_ROWS      = 36;

  // expected result of one query
  typedef struct packed {
    logic [LVL_W-1:0]  level_whole;
    logic [FRAC_W-1:0] level_fraction;
    logic              is_blending;
  } lod_t;

  typedef enum logic {ROW_QUERY, ROW_WRITE} row_kind_e;

  // one line of the directed table: a register write or a query
  typedef struct packed {
    row_kind_e          kind;
    dbdl_pkg::cfg_reg_e reg_idx;
    logic [DIST_W-1:0]  value;
    logic               typed;   // expected result given in the row
    lod_t               known;
  } step_row_t;

  typedef enum {SET_SORTED, SET_SCRAMBLED, SET_EXTREME} setting_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [23:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;

  // register mirror used by the level predictor
  logic [DIST_W-1:0] lvl_thr [3];
  logic [DIST_W-1:0] band_end_q [3];
  logic [CNT_W-1:0]  lvl_thr_cnt;
  logic [CNT_W-1:0]  band_cnt;

  lod_t        levels_due [$];
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned blended_seen;
  int unsigned mismatches;
  int unsigned in_stalls;
  int unsigned quiet_cycles;
  logic        tx_calm;
  logic        hold_req;

  distance_to_blended_detail_level_core #(
    .MAX_LEVELS(MAX_LEVELS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Level predictor. Level index = first threshold in use above the distance;
  // blend index found likewise among band ends, clamped to [level-1, level].
  // Band end capped by the threshold that follows, when one is in use.
  function automatic lod_t predict_level(logic [DIST_W-1:0] d);
    int unsigned       nt, nb, lvl, bi;
    logic [DIST_W-1:0] lo, hi;
    logic [63:0]       num, den;
    lod_t              r;
    nt  = (lvl_thr_cnt > MAX_LEVELS) ? MAX_LEVELS : lvl_thr_cnt;
    nb  = (band_cnt > MAX_LEVELS) ? MAX_LEVELS : band_cnt;
    r   = '0;
    lvl = nt;
    for (int i = 0; i < nt; i++) begin
      if (lvl == nt && lvl_thr[i] > d) lvl = i;
    end
    r.level_whole = LVL_W'(lvl);
    if (nb == 0 || lvl == 0) return r;
    bi = nb;
    for (int i = 0; i < nb; i++) begin
      if (bi == nb && band_end_q[i] > d) bi = i;
    end
    if (bi > lvl) bi = lvl;
    if (bi < lvl - 1) bi = lvl - 1;
    if (bi == lvl || bi >= nb) return r;
    lo = lvl_thr[bi];
    hi = band_end_q[bi];
    if (lvl < nt && lvl_thr[lvl] < hi) hi = lvl_thr[lvl];
    if (lo <= d && d < hi) begin
      num              = {32'b0, d - lo} << 16;
      den              = {32'b0, hi - lo};
      r.level_whole    = LVL_W'(bi);
      r.level_fraction = FRAC_W'(num / den);
      r.is_blending    = 1'b1;
    end
    return r;
  endfunction

  function automatic step_row_t write_row(dbdl_pkg::cfg_reg_e idx, logic [DIST_W-1:0] v);
    step_row_t r;
    r         = '0;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.value   = v;
    return r;
  endfunction

  function automatic step_row_t query_row(logic [DIST_W-1:0] d);
    step_row_t r;
    r       = '0;
    r.kind  = ROW_QUERY;
    r.value = d;
    return r;
  endfunction

  // query whose answer is plain: given level, no blending
  function automatic step_row_t known_row(logic [DIST_W-1:0] d, logic [LVL_W-1:0] lvl);
    step_row_t r;
    r                   = query_row(d);
    r.typed             = 1'b1;
    r.known.level_whole = lvl;
    return r;
  endfunction

  // random value spread over all magnitudes
  function automatic logic [DIST_W-1:0] scaled_rand();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  // mostly distances close to a threshold or band end, some at the extremes, some uniformly random
  function automatic logic [DIST_W-1:0] pick_distance();
    logic [DIST_W-1:0] base, off;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      default: begin
        base = $urandom_range(0, 1) ? lvl_thr[$urandom_range(0, 2)]
                                    : band_end_q[$urandom_range(0, 2)];
        off  = $urandom >> $urandom_range(12, 31);
        return $urandom_range(0, 1) ? base + off : base - off;
      end
    endcase
  endfunction

  task automatic write_reg(dbdl_pkg::cfg_reg_e idx, logic [DIST_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      dbdl_pkg::REG_THRESHOLD_A:     lvl_thr[0]    = v;
      dbdl_pkg::REG_THRESHOLD_B:     lvl_thr[1]    = v;
      dbdl_pkg::REG_THRESHOLD_C:     lvl_thr[2]    = v;
      dbdl_pkg::REG_BLEND_END_A:     band_end_q[0] = v;
      dbdl_pkg::REG_BLEND_END_B:     band_end_q[1] = v;
      dbdl_pkg::REG_BLEND_END_C:     band_end_q[2] = v;
      dbdl_pkg::REG_THRESHOLD_COUNT: lvl_thr_cnt   = v[CNT_W-1:0];
      dbdl_pkg::REG_BLEND_COUNT:     band_cnt      = v[CNT_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // entered and left just after a falling edge
  task automatic send_item(logic [DIST_W-1:0] d, logic typed, lod_t known);
    int unsigned gap;
    if (items_sent % 32 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    levels_due.push_back(typed ? known : predict_level(d));
    items_sent++;
    @(negedge clk_i);
  endtask

  // pipeline empty before the registers change
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (levels_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic log_mismatch(string what, lod_t want, lod_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: want lvl %0d frac %04h blend %0b, got lvl %0d frac %04h blend %0b pad %02h",
               what, want.level_whole, want.level_fraction, want.is_blending,
               got.level_whole, got.level_fraction, got.is_blending, m_axis_tdata[23:18]);
  endtask

  // result checker: every accepted item against the oldest expectation
  always @(posedge clk_i) begin : check_result
    lod_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.level_whole    = m_axis_tdata[1:0];
      got.level_fraction = m_axis_tdata[17:2];
      got.is_blending    = m_axis_tuser;
      if (levels_due.size() == 0) begin
        log_mismatch("result with nothing pending", '0, got);
      end else begin
        want = levels_due.pop_front();
        results_seen++;
        if (got.is_blending) blended_seen++;
        if (got !== want || m_axis_tdata[23:18] !== '0) log_mismatch("result differs", want, got);
      end
    end
  end

  // watchdog on handshake activity; also counts input stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if (s_axis_tvalid && !s_axis_tready) in_stalls <= in_stalls + 1;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result sink: random stalls per item, calm stretches, one long hold on request
  initial begin : sink
    int unsigned wait_n;
    int unsigned taken;
    logic        calm;
    m_axis_tready = 1'b0;
    taken         = 0;
    calm          = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      wait_n = calm ? 0 : $urandom_range(0, 7);
      if (hold_req) begin
        wait_n   = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (wait_n != 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    step_row_t         plan [PLAN_ROWS];
    logic              quiet;
    setting_e          kind;
    logic [DIST_W-1:0] t [3];
    logic [DIST_W-1:0] e [3];
    logic [DIST_W-1:0] tmp;
    logic [CNT_W-1:0]  tc, bc;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = dbdl_pkg::REG_THRESHOLD_A;
    cfg_data_i    = '0;
    lvl_thr       = '{default: '0};
    band_end_q    = '{default: '0};
    lvl_thr_cnt   = '0;
    band_cnt      = '0;
    items_sent    = 0;
    results_seen  = 0;
    blended_seen  = 0;
    mismatches    = 0;
    in_stalls     = 0;
    tx_calm       = 1'b0;
    hold_req      = 1'b0;

    // Directed table. Thresholds 1, 4, 16 with band ends 2, 8, 32 (Q16.16).
    plan = '{
      // after reset no threshold is in use: always level 0
      known_row(32'h0000_0000, 2'd0),
      known_row(32'hFFFF_FFFF, 2'd0),
      write_row(dbdl_pkg::REG_THRESHOLD_A,     32'h0001_0000),
      write_row(dbdl_pkg::REG_THRESHOLD_B,     32'h0004_0000),
      write_row(dbdl_pkg::REG_THRESHOLD_C,     32'h0010_0000),
      write_row(dbdl_pkg::REG_BLEND_END_A,     32'h0002_0000),
      write_row(dbdl_pkg::REG_BLEND_END_B,     32'h0008_0000),
      write_row(dbdl_pkg::REG_BLEND_END_C,     32'h0020_0000),
      write_row(dbdl_pkg::REG_THRESHOLD_COUNT, 32'd3),
      write_row(dbdl_pkg::REG_BLEND_COUNT,     32'd3),
      known_row(32'h0000_0000, 2'd0),
      query_row(32'h0001_0000),   // band start, fraction zero
      query_row(32'h0001_8000),   // mid band
      query_row(32'h0002_0000),   // band end excluded
      query_row(32'h0004_0000),
      query_row(32'h000F_FFFF),   // blend index clamps to level index
      query_row(32'h0010_0000),   // past the last threshold, last band
      query_row(32'h001F_FFFF),   // fraction just below one
      known_row(32'hFFFF_FFFF, 2'd3),
      // band end beyond the next threshold gets capped
      write_row(dbdl_pkg::REG_BLEND_END_A,     32'h0008_0000),
      query_row(32'h0003_0000),
      // blend index pulled up to level-1 onto an inverted band, then a short one
      write_row(dbdl_pkg::REG_THRESHOLD_B,     32'h0002_0000),
      write_row(dbdl_pkg::REG_BLEND_END_B,     32'h0000_8000),
      query_row(32'h0003_0000),
      write_row(dbdl_pkg::REG_BLEND_END_B,     32'h0002_8000),
      query_row(32'h0003_0000),   // outside the band
      query_row(32'h0002_4000),   // inside it
      // unsorted thresholds: first one already exceeds
      write_row(dbdl_pkg::REG_THRESHOLD_A,     32'h0010_0000),
      known_row(32'h0002_0000, 2'd0),
      // blending off
      write_row(dbdl_pkg::REG_BLEND_COUNT,     32'd0),
      known_row(32'h0011_0000, 2'd3),
      // blend index not below the blend count
      write_row(dbdl_pkg::REG_THRESHOLD_A,     32'h0001_0000),
      write_row(dbdl_pkg::REG_BLEND_COUNT,     32'd1),
      query_row(32'h0004_0000),
      // no thresholds in use
      write_row(dbdl_pkg::REG_THRESHOLD_COUNT, 32'd0),
      known_row(32'h1234_5678, 2'd0)
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    quiet = 1'b1;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        if (!quiet) wait_idle();
        quiet = 1'b1;
        write_reg(plan[r].reg_idx, plan[r].value);
      end else begin
        send_item(plan[r].value, plan[r].typed, plan[r].known);
        quiet = 1'b0;
      end
    end

    // Random phases: each rewrites every register, then queries mostly near the edges.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      if (phase == 0 || phase == PHASES - 1) kind = SET_EXTREME;
      else if (phase % 3 == 0)               kind = SET_SCRAMBLED;
      else                                   kind = SET_SORTED;
      case (kind)
        SET_SORTED: begin
          for (int k = 0; k < 3; k++) t[k] = scaled_rand();
          if (t[0] > t[1]) begin tmp = t[0]; t[0] = t[1]; t[1] = tmp; end
          if (t[1] > t[2]) begin tmp = t[1]; t[1] = t[2]; t[2] = tmp; end
          if (t[0] > t[1]) begin tmp = t[0]; t[0] = t[1]; t[1] = tmp; end
          for (int k = 0; k < 3; k++) begin
            e[k] = t[k] + scaled_rand();
            if (e[k] < t[k]) e[k] = '1;
            if ($urandom_range(0, 5) == 0) e[k] = scaled_rand();  // may invert
          end
          tc = $urandom_range(0, 1) ? CNT_W'(3) : CNT_W'($urandom_range(0, 3));
          bc = $urandom_range(0, 1) ? CNT_W'(3) : CNT_W'($urandom_range(0, 3));
        end
        SET_SCRAMBLED: begin
          for (int k = 0; k < 3; k++) begin
            t[k] = scaled_rand();
            e[k] = scaled_rand();
          end
          tc = CNT_W'($urandom_range(0, 3));
          bc = CNT_W'($urandom_range(0, 3));
        end
        default: begin
          for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 3))
              0: t[k] = '0;
              1: t[k] = 32'd1;
              2: t[k] = 32'hFFFF_FFFE;
              default: t[k] = '1;
            endcase
            case ($urandom_range(0, 3))
              0: e[k] = '0;
              1: e[k] = 32'd1;
              2: e[k] = 32'hFFFF_FFFE;
              default: e[k] = '1;
            endcase
          end
          tc = (phase == 0 || $urandom_range(0, 1)) ? CNT_W'(3) : '0;
          bc = (phase == 0 || $urandom_range(0, 1)) ? CNT_W'(3) : '0;
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        write_reg(dbdl_pkg::cfg_reg_e'(dbdl_pkg::REG_THRESHOLD_A + k), t[k]);
        write_reg(dbdl_pkg::cfg_reg_e'(dbdl_pkg::REG_BLEND_END_A + k), e[k]);
      end
      write_reg(dbdl_pkg::REG_THRESHOLD_COUNT, 32'(tc));
      write_reg(dbdl_pkg::REG_BLEND_COUNT,     32'(bc));

      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        // one long hold on the output while items keep coming
        if (phase == 2 && k == 20) hold_req = 1'b1;
        send_item(pick_distance(), 1'b0, '0);
      end
    end
    wait_idle();

    $display("Covered %0d distance queries (%0d blended) over directed rows and %0d random setups.",
             items_sent, blended_seen, PHASES);
    $display("Input held off %0d cycles by back-pressure; %0d results checked, %0d mismatches.",
             in_stalls, results_seen, mismatches);
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dbdl_pkg.sv
rtl/core/dbdl_div.sv
rtl/core/distance_to_blended_detail_level_core.sv
rtl/core/dbdl_checker.sv
tb/distance_to_blended_detail_level_core_tb.sv
